>>> design/rscg_pkg.sv
package rscg_pkg;

   localparam int CoordWidth = 16;
   localparam int CountWidth = 32;
   localparam int WidthBits  = CoordWidth + 1;
   localparam int IterBits   = $clog2(CountWidth);

   typedef enum logic [1:0] {
      CMD_RESTART = 2'd0,
      CMD_NEXT    = 2'd1,
      CMD_SKIP    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_LEFT   = 2'd0,
      CSR_TOP    = 2'd1,
      CSR_RIGHT  = 2'd2,
      CSR_BOTTOM = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic restart;
      logic step;
      logic div_start;
      logic div_step;
      logic finish;
   } dp_cmd_type;

endpackage

>>> design/raster_scan_coordinate_generator.sv
// Raster scan coordinate generator.
// Configure left, top, right and bottom edges through the csr_ write channel
// (index 0..3, low 16 bits of csr_data), only while the block is idle; csr_ready
// is always high. Each request transaction carries a command:
//   restart - cursor moves to (left, top), no response
//   next    - responds with the current (x, y), then steps right, wrapping to
//             the left edge and the next row past the right edge
//   skip    - moves the cursor ahead by req_skip_count pixels, no response
// A next transaction shows its response in the cycle after acceptance, and the
// block takes one next or restart per cycle unless the response is stalled. A skip
// runs a radix-2 divide by the rectangle width, one quotient bit per cycle, in
// steps: load at acceptance, 32 divide steps, update; req_stall stays high
// through the divide steps and the update.
// If the receiver stalls, the response holds and req_stall rises so no
// further transaction is accepted until the response is taken.
// Synchronous reset clears the left, top and right edges and the cursor to zero and drops rsp_valid.
module raster_scan_coordinate_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_cmd,
   input  logic [rscg_pkg::CountWidth-1:0]        req_skip_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [rscg_pkg::CoordWidth-1:0] rsp_pixel_x,
   output logic signed [rscg_pkg::CoordWidth-1:0] rsp_pixel_y,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [rscg_pkg::CoordWidth-1:0]        csr_data
);

   rscg_pkg::dp_cmd_type dp_cmd;

   assign csr_ready = 1'b1;

   rscg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   rscg_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .req_skip_count (req_skip_count),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y)
   );

endmodule

>>> design/rscg_ctrl.sv
module rscg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rscg_pkg::dp_cmd_type  dp_cmd
);

   rscg_pkg::state_type state_ff, state_in;
   logic [rscg_pkg::IterBits-1:0] iter_ff, iter_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic last_iter;

   assign req_stall = (state_ff != rscg_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign last_iter = (iter_ff == rscg_pkg::IterBits'(rscg_pkg::CountWidth - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rscg_pkg::ST_IDLE: begin
            if (accept && req_cmd == rscg_pkg::CMD_SKIP) begin
               state_in = rscg_pkg::ST_DIV;
            end
         end
         rscg_pkg::ST_DIV: begin
            if (last_iter) begin
               state_in = rscg_pkg::ST_FIN;
            end
         end
         rscg_pkg::ST_FIN: begin
            state_in = rscg_pkg::ST_IDLE;
         end
         default: begin
            state_in = rscg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      dp_cmd       = '0;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         rscg_pkg::ST_IDLE: begin
            iter_in = '0;
            if (accept) begin
               unique case (req_cmd)
                  rscg_pkg::CMD_RESTART: dp_cmd.restart = 1'b1;
                  rscg_pkg::CMD_NEXT: begin
                     dp_cmd.step  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  rscg_pkg::CMD_SKIP: dp_cmd.div_start = 1'b1;
                  default: ;
               endcase
            end
         end
         rscg_pkg::ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
         end
         rscg_pkg::ST_FIN: begin
            dp_cmd.finish = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rscg_pkg::ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/rscg_dp.sv
module rscg_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rscg_pkg::dp_cmd_type                   dp_cmd,
   input  logic [rscg_pkg::CountWidth-1:0]        req_skip_count,
   input  logic                                   csr_we,
   input  logic [1:0]                             csr_index,
   input  logic [rscg_pkg::CoordWidth-1:0]        csr_data,
   output logic signed [rscg_pkg::CoordWidth-1:0] rsp_pixel_x,
   output logic signed [rscg_pkg::CoordWidth-1:0] rsp_pixel_y
);

   localparam int CW = rscg_pkg::CoordWidth;
   localparam int WW = rscg_pkg::WidthBits;
   localparam int NW = CW + 3;

   logic [CW-1:0] left_ff, top_ff, right_ff;
   logic [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0] out_x_ff, out_y_ff;
   logic [rscg_pkg::CountWidth-1:0] dvd_ff, dvd_in;
   logic [WW-1:0] rem_ff, rem_in;
   logic [WW-1:0] rect_w;
   logic [WW:0]   rem_try;
   logic          rem_ge;
   logic signed [NW-1:0] nx, right_ext;
   logic [NW-1:0] nx_wrap;
   logic [CW-1:0] diff;

   assign diff      = right_ff - left_ff;
   assign rect_w    = {1'b0, diff} + WW'(1);
   assign rem_try   = {rem_ff, dvd_ff[rscg_pkg::CountWidth-1]};
   assign rem_ge    = rem_try >= {1'b0, rect_w};
   assign nx        = NW'($signed(cur_x_ff)) + $signed({2'b00, rem_ff});
   assign right_ext = NW'($signed(right_ff));
   assign nx_wrap   = nx - {2'b00, rect_w};

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      if (dp_cmd.restart) begin
         cur_x_in = left_ff;
         cur_y_in = top_ff;
      end else if (dp_cmd.step) begin
         if ($signed(cur_x_ff) < $signed(right_ff)) begin
            cur_x_in = cur_x_ff + 1'b1;
         end else begin
            cur_x_in = left_ff;
            cur_y_in = cur_y_ff + 1'b1;
         end
      end else if (dp_cmd.div_start) begin
         dvd_in = req_skip_count;
         rem_in = '0;
      end else if (dp_cmd.div_step) begin
         if (rem_ge) begin
            rem_in = WW'(rem_try - {1'b0, rect_w});
         end else begin
            rem_in = rem_try[WW-1:0];
         end
         dvd_in = {dvd_ff[rscg_pkg::CountWidth-2:0], rem_ge};
      end else if (dp_cmd.finish) begin
         if (nx > right_ext) begin
            cur_x_in = nx_wrap[CW-1:0];
            cur_y_in = cur_y_ff + dvd_ff[CW-1:0] + 1'b1;
         end else begin
            cur_x_in = nx[CW-1:0];
            cur_y_in = cur_y_ff + dvd_ff[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= '0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         if (csr_we) begin
            unique case (csr_index)
               rscg_pkg::CSR_LEFT:   left_ff   <= csr_data;
               rscg_pkg::CSR_TOP:    top_ff    <= csr_data;
               rscg_pkg::CSR_RIGHT:  right_ff  <= csr_data;
               // bottom edge never bounds the walk
               rscg_pkg::CSR_BOTTOM: ;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (dp_cmd.step) begin
         out_x_ff <= cur_x_ff;
         out_y_ff <= cur_y_ff;
      end
   end

   assign rsp_pixel_x = $signed(out_x_ff);
   assign rsp_pixel_y = $signed(out_y_ff);

endmodule

>>> design/rscg_chk.sv
module rscg_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic [1:0]                             req_cmd,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [rscg_pkg::CoordWidth-1:0] rsp_pixel_x,
   input logic signed [rscg_pkg::CoordWidth-1:0] rsp_pixel_y
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_x) && $stable(rsp_pixel_y))
      else $error("stalled response changed");

   a_next_resp: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_cmd == rscg_pkg::CMD_NEXT |=> rsp_valid)
      else $error("next transaction gave no response");

   a_skip_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_cmd == rscg_pkg::CMD_SKIP |=> req_stall)
      else $error("request taken during skip");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response stalled");

endmodule

bind raster_scan_coordinate_generator rscg_chk u_rscg_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_cmd     (req_cmd),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pixel_x (rsp_pixel_x),
   .rsp_pixel_y (rsp_pixel_y)
);
